// File: sv/gdk_pkg.sv
// ----------------------------------------------------------------------------
// gdk_pkg
// Shared widths, register indexes, exponent tables and request struct for
// the grid dispersal kernel.
// ----------------------------------------------------------------------------
`default_nettype none

package gdk_pkg;

   // default grid shape
   localparam int ROWS_DEFAULT = 8;
   localparam int COLS_DEFAULT = 8;

   // field widths
   localparam int SUIT_W   = 16;
   localparam int DECAY_W  = 16;
   localparam int POS_W    = 3;
   localparam int DIFF_W   = 6;
   localparam int WEIGHT_W = 24;
   localparam int TOTAL_W  = 30;
   localparam int PROB_W   = 16;
   localparam int CSR_W    = 2;
   localparam int RSP_W    = 24;

   localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd1229;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 30'h3FFF_FFFF;

   // register indexes
   typedef enum logic [CSR_W-1:0] {
      CSR_DECAY_RATE = 2'd0,
      CSR_START_ROW  = 2'd1,
      CSR_START_COL  = 2'd2
   } csr_index_type;

   // exp(-n) for integer n, Q.16
   localparam logic [16:0] EXP_INT [12] = '{
      17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442,
      17'd162,   17'd60,    17'd22,   17'd8,    17'd3,    17'd1
   };

   // exp(-2^-k) for k = 1..12, Q.16
   localparam logic [15:0] EXP_FRAC [12] = '{
      16'd39750, 16'd51039, 16'd57835, 16'd61565, 16'd63520, 16'd64520,
      16'd65026, 16'd65281, 16'd65408, 16'd65472, 16'd65504, 16'd65520
   };

   // request to the weight unit
   typedef struct packed {
      logic                start;
      logic [SUIT_W-1:0]   suitability;
      logic [DIFF_W-1:0]   diff_row;
      logic [DIFF_W-1:0]   diff_col;
      logic [DECAY_W-1:0]  decay_rate;
   } calc_req_type;

endpackage

`default_nettype wire

// File: sv/gdk_weight_ram.sv
// ----------------------------------------------------------------------------
// gdk_weight_ram
// Simple dual-port weight store, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gdk_weight_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 24
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/gdk_weight_calc.sv
// ----------------------------------------------------------------------------
// gdk_weight_calc
// Per-cell weight: bit-serial square root of the distance, exponent scale,
// exp(-x) by table and twelve fractional multiply steps, suitability squared.
// ----------------------------------------------------------------------------
`default_nettype none

module gdk_weight_calc (
   input  logic                          clock,
   input  logic                          reset,
   input  gdk_pkg::calc_req_type         calc_req,
   output logic                          calc_done,
   output logic [gdk_pkg::WEIGHT_W-1:0]  calc_weight
);
   import gdk_pkg::*;

   typedef enum logic [5:0] {
      WC_IDLE  = 6'b000001,
      WC_SQRT  = 6'b000010,
      WC_SCALE = 6'b000100,
      WC_BASE  = 6'b001000,
      WC_FRAC  = 6'b010000,
      WC_MUL   = 6'b100000
   } calc_state_type;

   calc_state_type state_ff, state_in;
   logic [3:0]          step_ff, step_in;
   logic [31:0]         rad_ff, rad_in;
   logic [31:0]         root_ff, root_in;
   logic [31:0]         probe_ff, probe_in;
   logic [SUIT_W-1:0]   suit_ff, suit_in;
   logic [DECAY_W-1:0]  decay_ff, decay_in;
   logic [15:0]         sq_ff, sq_in;
   logic [23:0]         expo_ff, expo_in;
   logic [16:0]         e_ff, e_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic                done_ff, done_in;

   logic [12:0] dist_sq;
   logic [31:0] trial;
   logic [31:0] scale_prod;
   logic [31:0] suit_prod;
   logic [32:0] frac_prod;
   logic [32:0] weight_prod;
   logic [11:0] expo_int;
   logic [11:0] frac_shift;

   // datapath terms
   assign dist_sq     = 13'(calc_req.diff_row) * 13'(calc_req.diff_row)
                      + 13'(calc_req.diff_col) * 13'(calc_req.diff_col);
   assign trial       = root_ff + probe_ff;
   assign scale_prod  = decay_ff * root_ff[15:0];
   assign suit_prod   = suit_ff * suit_ff;
   assign frac_prod   = 33'(e_ff) * 33'(EXP_FRAC[step_ff]);
   assign weight_prod = 33'(e_ff) * 33'(sq_ff);
   assign expo_int    = expo_ff[23:12];
   assign frac_shift  = expo_ff[11:0] >> (4'd11 - step_ff);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      rad_in    = rad_ff;
      root_in   = root_ff;
      probe_in  = probe_ff;
      suit_in   = suit_ff;
      decay_in  = decay_ff;
      sq_in     = sq_ff;
      expo_in   = expo_ff;
      e_in      = e_ff;
      weight_in = weight_ff;
      done_in   = 1'b0;
      case (state_ff)
         WC_IDLE: begin
            if (calc_req.start) begin
               rad_in   = {3'd0, dist_sq, 16'd0};
               root_in  = 32'd0;
               probe_in = 32'h4000_0000;
               step_in  = 4'd0;
               suit_in  = calc_req.suitability;
               decay_in = calc_req.decay_rate;
               state_in = WC_SQRT;
            end
         end
         WC_SQRT: begin
            if (rad_ff >= trial) begin
               rad_in  = rad_ff - trial;
               root_in = (root_ff >> 1) + probe_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            probe_in = probe_ff >> 2;
            step_in  = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               state_in = WC_SCALE;
            end
         end
         WC_SCALE: begin
            expo_in  = scale_prod[31:8];
            sq_in    = suit_prod[31:16];
            state_in = WC_BASE;
         end
         WC_BASE: begin
            e_in     = (expo_int < 12'd12) ? EXP_INT[expo_int[3:0]] : 17'd0;
            step_in  = 4'd0;
            state_in = WC_FRAC;
         end
         WC_FRAC: begin
            if (frac_shift[0]) begin
               e_in = frac_prod[32:16];
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd11) begin
               state_in = WC_MUL;
            end
         end
         WC_MUL: begin
            weight_in = weight_prod[31:8];
            done_in   = 1'b1;
            state_in  = WC_IDLE;
         end
         default: begin
            state_in = WC_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      rad_ff    <= rad_in;
      root_ff   <= root_in;
      probe_ff  <= probe_in;
      suit_ff   <= suit_in;
      decay_ff  <= decay_in;
      sq_ff     <= sq_in;
      expo_ff   <= expo_in;
      e_ff      <= e_in;
      weight_ff <= weight_in;
   end

   assign calc_done   = done_ff;
   assign calc_weight = weight_ff;

endmodule

`default_nettype wire

// File: sv/gdk_normalizer.sv
// ----------------------------------------------------------------------------
// gdk_normalizer
// Walks the weight store in raster order and divides each weight by the
// total with a restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gdk_normalizer #(
   parameter int GRID_COLS  = 8,
   parameter int CELL_COUNT = 64,
   parameter int IDX_W      = 6,
   parameter int ROW_W      = 3,
   parameter int COL_W      = 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         norm_start,
   input  logic [gdk_pkg::TOTAL_W-1:0]  norm_total,
   output logic                         norm_done,
   output logic                         rd_en,
   output logic [IDX_W-1:0]             rd_addr,
   input  logic [gdk_pkg::WEIGHT_W-1:0] rd_data,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [gdk_pkg::RSP_W-1:0]    rsp_tdata,
   output logic                         rsp_tuser,
   output logic                         rsp_tlast
);
   import gdk_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELL_COUNT - 1);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_COLS - 1);

   typedef enum logic [4:0] {
      NM_IDLE = 5'b00001,
      NM_READ = 5'b00010,
      NM_LOAD = 5'b00100,
      NM_DIV  = 5'b01000,
      NM_OUT  = 5'b10000
   } norm_state_type;

   norm_state_type state_ff, state_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W-1:0] rem_ff, rem_in;
   logic [PROB_W-1:0]  quot_ff, quot_in;
   logic [3:0]         step_ff, step_in;
   logic               zero_ff, zero_in;
   logic               done_ff, done_in;

   logic [TOTAL_W:0]   shifted;
   logic [TOTAL_W:0]   diff;

   assign shifted = {rem_ff, 1'b0};
   assign diff    = shifted - {1'b0, total_ff};

   // sequencer
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      total_in = total_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      zero_in  = zero_ff;
      done_in  = 1'b0;
      rd_en    = 1'b0;
      case (state_ff)
         NM_IDLE: begin
            if (norm_start) begin
               total_in = norm_total;
               addr_in  = '0;
               row_in   = '0;
               col_in   = '0;
               state_in = NM_READ;
            end
         end
         NM_READ: begin
            rd_en    = 1'b1;
            state_in = NM_LOAD;
         end
         NM_LOAD: begin
            zero_in = 1'b0;
            if (total_ff == '0) begin
               quot_in  = '0;
               zero_in  = 1'b1;
               state_in = NM_OUT;
            end else if (TOTAL_W'(rd_data) >= total_ff) begin
               // weight reaches or exceeds total: quotient saturates
               quot_in  = '1;
               state_in = NM_OUT;
            end else begin
               rem_in   = TOTAL_W'(rd_data);
               quot_in  = '0;
               step_in  = 4'd0;
               state_in = NM_DIV;
            end
         end
         NM_DIV: begin
            if (shifted >= {1'b0, total_ff}) begin
               rem_in  = diff[TOTAL_W-1:0];
               quot_in = {quot_ff[PROB_W-2:0], 1'b1};
            end else begin
               rem_in  = shifted[TOTAL_W-1:0];
               quot_in = {quot_ff[PROB_W-2:0], 1'b0};
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               state_in = NM_OUT;
            end
         end
         NM_OUT: begin
            if (rsp_tready) begin
               if (addr_ff == LAST_IDX) begin
                  done_in  = 1'b1;
                  state_in = NM_IDLE;
               end else begin
                  addr_in = addr_ff + 1'b1;
                  if (col_ff == LAST_COL) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
                  state_in = NM_READ;
               end
            end
         end
         default: begin
            state_in = NM_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= NM_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      total_ff <= total_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      step_ff  <= step_in;
      zero_ff  <= zero_in;
   end

   // result transaction
   assign rd_addr    = addr_ff;
   assign norm_done  = done_ff;
   assign rsp_tvalid = (state_ff == NM_OUT);
   assign rsp_tdata  = {2'b00, quot_ff, POS_W'(col_ff), POS_W'(row_ff)};
   assign rsp_tuser  = zero_ff;
   assign rsp_tlast  = (addr_ff == LAST_IDX);

endmodule

`default_nettype wire

// File: sv/grid_dispersal_kernel_top.sv
// A cell is taken, and the next one once the weight unit has run its 16-step
// square root, exponent scale, table lookup, 12-step fractional exponent and
// final multiply and the weight is stored. After the last cell the results
// follow in raster order: store read, 16-step divider, output register; a
// zero total or a weight that reaches the total skips the divider.
// Reset is synchronous and active high; it clears control state and
// registers. The weight store is not cleared: each entry is written first.
// ----------------------------------------------------------------------------
// grid_dispersal_kernel_top
// Normalized exponential distance-decay kernel over a raster grid.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_dispersal_kernel_top #(
   parameter int GRID_ROWS = gdk_pkg::ROWS_DEFAULT,
   parameter int GRID_COLS = gdk_pkg::COLS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // req_tdata: suitability[15:0]
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [gdk_pkg::SUIT_W-1:0]   req_tdata,
   // rsp_tdata: out_row[2:0], out_col[5:3], probability[21:6], zero pad[23:22]
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [gdk_pkg::RSP_W-1:0]    rsp_tdata,
   // rsp_tuser: zero_total[0]
   output logic                         rsp_tuser,
   output logic                         rsp_tlast,
   input  logic                         csr_we,
   input  logic [gdk_pkg::CSR_W-1:0]    csr_index,
   input  logic [gdk_pkg::DECAY_W-1:0]  csr_wdata
);
   import gdk_pkg::*;

   localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
   localparam int IDX_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int COL_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELL_COUNT - 1);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_COLS - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_EMIT = 3'b100
   } top_state_type;

   top_state_type state_ff, state_in;
   logic [DECAY_W-1:0] decay_ff;
   logic [POS_W-1:0]   start_row_ff;
   logic [POS_W-1:0]   start_col_ff;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   calc_req_type        calc_req;
   logic                calc_done;
   logic [WEIGHT_W-1:0] calc_weight;
   logic [DIFF_W-1:0]   row_ext, col_ext, srow_ext, scol_ext;
   logic [TOTAL_W:0]    sum_wide;
   logic [TOTAL_W-1:0]  sat_total;
   logic                wr_en;
   logic                norm_start;
   logic                norm_done;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [WEIGHT_W-1:0] rd_data;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff     <= DECAY_RESET;
         start_row_ff <= '0;
         start_col_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DECAY_RATE: decay_ff     <= csr_wdata;
            CSR_START_ROW:  start_row_ff <= csr_wdata[POS_W-1:0];
            CSR_START_COL:  start_col_ff <= csr_wdata[POS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // distance offsets from the start cell
   assign row_ext  = DIFF_W'(row_ff);
   assign col_ext  = DIFF_W'(col_ff);
   assign srow_ext = DIFF_W'(start_row_ff);
   assign scol_ext = DIFF_W'(start_col_ff);

   assign req_tready           = (state_ff == ST_IDLE);
   assign calc_req.start       = req_tvalid & req_tready;
   assign calc_req.suitability = req_tdata;
   assign calc_req.diff_row    = (row_ext > srow_ext) ? row_ext - srow_ext : srow_ext - row_ext;
   assign calc_req.diff_col    = (col_ext > scol_ext) ? col_ext - scol_ext : scol_ext - col_ext;
   assign calc_req.decay_rate  = decay_ff;

   // saturating running total
   assign sum_wide  = {1'b0, total_ff} + (TOTAL_W + 1)'(calc_weight);
   assign sat_total = (sum_wide > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];

   // load sequencer
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      total_in   = total_ff;
      wr_en      = 1'b0;
      norm_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (calc_req.start) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (calc_done) begin
               wr_en = 1'b1;
               if (idx_ff == LAST_IDX) begin
                  norm_start = 1'b1;
                  total_in   = '0;
                  idx_in     = '0;
                  row_in     = '0;
                  col_in     = '0;
                  state_in   = ST_EMIT;
               end else begin
                  total_in = sat_total;
                  idx_in   = idx_ff + 1'b1;
                  if (col_ff == LAST_COL) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (norm_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         total_ff <= total_in;
      end
   end

   // weight unit
   gdk_weight_calc u_calc (
      .clock       (clock),
      .reset       (reset),
      .calc_req    (calc_req),
      .calc_done   (calc_done),
      .calc_weight (calc_weight)
   );

   // weight store
   gdk_weight_ram #(
      .DEPTH  (CELL_COUNT),
      .ADDR_W (IDX_W),
      .DATA_W (WEIGHT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (calc_weight),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // emit walk and divider
   gdk_normalizer #(
      .GRID_COLS  (GRID_COLS),
      .CELL_COUNT (CELL_COUNT),
      .IDX_W      (IDX_W),
      .ROW_W      (ROW_W),
      .COL_W      (COL_W)
   ) u_norm (
      .clock      (clock),
      .reset      (reset),
      .norm_start (norm_start),
      .norm_total (sat_total),
      .norm_done  (norm_done),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: sv/gdk_checker.sv
// ----------------------------------------------------------------------------
// gdk_checker
// Port-level checks on the grid dispersal kernel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gdk_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tready,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast
);

   // no cell taken while results are going out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted during emit");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // zero total forces a zero probability
   a_zero_prob: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[21:6] == 16'd0)
      else $error("nonzero probability with zero total");

   // the grid ends after its last result
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("result after last of grid");

endmodule

bind grid_dispersal_kernel_top gdk_checker u_gdk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// File: test/grid_dispersal_kernel_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_dispersal_kernel_top_tb
// Loads whole 8x8 suitability grids under several decay and start-cell
// settings and checks every normalized probability, cell position, zero-total
// flag and end-of-grid mark against a fixed-point predictor of the kernel.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_dispersal_kernel_top_tb;
   import gdk_pkg::*;

   localparam int CELLS = 64;

   // one normalized cell as it leaves the block
   typedef struct packed {
      logic [2:0]  row;
      logic [2:0]  col;
      logic [15:0] prob;
      logic        zero_total;
      logic        last;
   } cell_prob_type;

   // kernel predictor with its own copy of registers and grid state
   class dispersal_scoreboard;
      logic [15:0] decay;
      logic [2:0]  srow, scol;
      logic [23:0] weights [CELLS];
      logic [29:0] total;
      int          load_idx;
      cell_prob_type pending [$];
      int          errors;

      function new();
         decay = DECAY_RESET; srow = 0; scol = 0;
         total = 0; load_idx = 0; errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [15:0] val);
         case (idx)
            CSR_DECAY_RATE: decay = val;
            CSR_START_ROW: srow = val[2:0];
            CSR_START_COL: scol = val[2:0];
            default: ;
         endcase
      endfunction

      function automatic logic [31:0] int_sqrt(logic [31:0] v);
         logic [31:0] root, bitv;
         root = 0; bitv = 32'h4000_0000;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= root + bitv) begin
               v -= root + bitv;
               root = (root >> 1) + bitv;
            end else begin
               root >>= 1;
            end
            bitv >>= 2;
         end
         return root;
      endfunction

      function automatic logic [23:0] cell_weight(int r, int c, logic [15:0] suit);
         int dr, dc;
         logic [63:0] d8, x12, e, s2;
         dr = r > srow ? r - srow : srow - r;
         dc = c > scol ? c - scol : scol - c;
         d8 = int_sqrt((dr * dr + dc * dc) << 16);
         x12 = (64'(decay) * d8) >> 8;
         if ((x12 >> 12) >= 12) begin
            e = 0;
         end else begin
            e = EXP_INT[x12 >> 12];
            for (int k = 1; k <= 12; k++)
               if (x12[12-k]) e = (e * EXP_FRAC[k-1]) >> 16;
         end
         s2 = (64'(suit) * suit) >> 16;
         return 24'((e * s2) >> 8);
      endfunction

      // note an accepted cell; the last cell of a grid queues all probabilities
      function void note_cell(logic [15:0] suit);
         logic [63:0] sum, p;
         cell_prob_type c;
         weights[load_idx] = cell_weight(load_idx / 8, load_idx % 8, suit);
         sum = 64'(total) + weights[load_idx];
         total = sum > TOTAL_MAX ? TOTAL_MAX : sum[29:0];
         if (load_idx + 1 < CELLS) begin
            load_idx++;
            return;
         end
         for (int i = 0; i < CELLS; i++) begin
            p = 0;
            if (total != 0) begin
               p = (64'(weights[i]) << 16) / total;
               if (p > 65535) p = 65535;
            end
            c.row = 3'(i / 8); c.col = 3'(i % 8); c.prob = p[15:0];
            c.zero_total = total == 0; c.last = i == CELLS - 1;
            pending.push_back(c);
         end
         total = 0; load_idx = 0;
      endfunction

      function void check_cell(cell_prob_type got);
         cell_prob_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result: %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("result mismatch: expected %p actual %p", want, got);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser, rsp_tlast;
   logic        csr_we = 0;
   logic [CSR_W-1:0] csr_index = 0;
   logic [15:0] csr_wdata = 0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off = 0;
   int hold_req = 0;
   int hold_seen = 0;
   dispersal_scoreboard sb = new();

   grid_dispersal_kernel_top u_top (.*);

   always #2 clock = ~clock;

   // receiver: random stalls plus a counted hold-off stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_off <= 3000;
         rsp_tready <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_cell({rsp_tdata[2:0], rsp_tdata[5:3], rsp_tdata[21:6],
                        rsp_tuser, rsp_tlast});
   end

   // offer one cell; valid stays up into the next call when there is no gap
   task automatic send_cell(logic [15:0] suit);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= suit;
      do @(posedge clock); while (!req_tready);
      sb.note_cell(suit);
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
      csr_we <= 0;
      @(posedge clock);
   endtask

   // kind 0 random, 1 all zero, 2 all max, 3 walking bits
   task automatic send_grid(int kind);
      logic [15:0] v;
      for (int i = 0; i < CELLS; i++) begin
         case (kind)
            1: v = 0;
            2: v = 16'hFFFF;
            3: v = 16'h1 << (i % 16);
            default: v = ($urandom_range(3) == 0) ? 16'($urandom_range(255))
                                                  : 16'($urandom());
         endcase
         send_cell(v);
      end
      req_tvalid <= 0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // zero grid at reset registers, random grid, then a saturating grid
      // under a long receiver hold-off
      for (int g = 0; g < 3; g++) begin
         send_idle_pct = g == 0 ? 19 : (g == 1 ? 77 : 0);
         recv_idle_pct = g == 0 ? 77 : (g == 1 ? 19 : 0);
         if (g == 1) begin
            write_reg(CSR_DECAY_RATE, $urandom_range(3) == 0 ? 16'($urandom())
                                                            : 16'($urandom_range(8000)));
            write_reg(CSR_START_ROW, 16'($urandom_range(7)));
            write_reg(CSR_START_COL, 16'($urandom_range(7)));
            send_grid(0);
         end else if (g == 2) begin
            write_reg(CSR_DECAY_RATE, 16'hFFFF);
            write_reg(CSR_START_ROW, 16'd3);
            write_reg(CSR_START_COL, 16'd4);
            hold_req++;
            send_grid(2);
         end else begin
            send_grid(1);
         end
         drain();
      end

      if (sb.pending.size() != 0 || sb.errors != 0) begin
         $display("SCOREBOARD MISMATCH");
      end else begin
         $display("SCOREBOARD CLEAN");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

`default_nettype wire
